[sv/bba_pkg.sv]
// shared types, constants and helpers for the bitmap block allocator
// no dependencies
`default_nettype none

package bba_pkg;

   localparam int NUM_BLOCKS_DEF = 256;
   localparam int WORD_W         = 64;
   localparam int POS_W          = 6;
   localparam int DEPTH_DEF      = (NUM_BLOCKS_DEF + WORD_W - 1) / WORD_W;
   localparam int ADDR_W_DEF     = (DEPTH_DEF > 1) ? $clog2(DEPTH_DEF) : 1;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_REQUEST = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] blk_num;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [7:0] granted_block;
      logic [7:0] used_count;
      logic [7:0] free_count;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic       status;
      logic [7:0] granted;
      logic       inc;
      logic       dec;
   } done_type;

   // position of the lowest zero bit, zero when the word is full
   function automatic logic [POS_W-1:0] first_zero(input logic [WORD_W-1:0] w);
      logic [POS_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) begin
            pos = POS_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

[sv/bba_map_mem.sv]
// used-block bitmap storage, one map word per entry, registered read
// depends on bba_pkg
`default_nettype none

module bba_map_mem #(
   parameter int DEPTH  = bba_pkg::DEPTH_DEF,
   parameter int ADDR_W = bba_pkg::ADDR_W_DEF
) (
   input  wire logic                       clock,
   input  wire logic [ADDR_W-1:0]          rd_addr,
   output logic      [bba_pkg::WORD_W-1:0] rd_data,
   input  wire logic                       wr_en,
   input  wire logic [ADDR_W-1:0]          wr_addr,
   input  wire logic [bba_pkg::WORD_W-1:0] wr_data
);

   logic [bba_pkg::WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[sv/bba_ctrl.sv]
// command sequencer: clearing pass, read-modify-write of map words, first-fit scan
// depends on bba_pkg
`default_nettype none

module bba_ctrl #(
   parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
   parameter int DEPTH      = bba_pkg::DEPTH_DEF,
   parameter int ADDR_W     = bba_pkg::ADDR_W_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire bba_pkg::req_type           req,
   output logic      [ADDR_W-1:0]          mem_rd_addr,
   input  wire logic [bba_pkg::WORD_W-1:0] mem_rd_data,
   output logic                            mem_wr_en,
   output logic      [ADDR_W-1:0]          mem_wr_addr,
   output logic      [bba_pkg::WORD_W-1:0] mem_wr_data,
   output bba_pkg::done_type               done
);

   localparam int POS_W = bba_pkg::POS_W;
   localparam int IDX_W = ADDR_W + POS_W;
   localparam int BLK_W = $clog2(NUM_BLOCKS);
   localparam int ID_W  = (BLK_W > 8) ? BLK_W : 8;
   localparam logic [ID_W-1:0]   ID_LIMIT  = ID_W'(NUM_BLOCKS - 1);
   localparam logic [IDX_W-1:0]  IDX_LIMIT = IDX_W'(NUM_BLOCKS - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   bba_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [7:0]         id_ff, id_in;

   logic               accept;
   logic               req_id_ok;
   logic               id_ok;
   logic [POS_W-1:0]   id_pos;
   logic               id_bit;
   logic               word_full;
   logic [POS_W-1:0]   zero_pos;
   logic [IDX_W-1:0]   zero_idx;
   logic               zero_ok;
   logic               scan_more;

   assign busy      = (state_ff != bba_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign req_id_ok = ID_W'(req.blk_num) < ID_LIMIT;
   assign id_ok     = ID_W'(id_ff) < ID_LIMIT;
   assign id_pos    = id_ff[POS_W-1:0];
   assign id_bit    = mem_rd_data[id_pos];
   assign word_full = &mem_rd_data;
   assign zero_pos  = bba_pkg::first_zero(mem_rd_data);
   assign zero_idx  = {addr_ff, zero_pos};
   assign zero_ok   = !word_full && (zero_idx < IDX_LIMIT);
   assign scan_more = (cmd_ff == bba_pkg::CMD_ALLOC) && word_full && (addr_ff != LAST_ADDR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::ST_CLEAR;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      id_ff  <= id_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      cmd_in   = cmd_ff;
      id_in    = id_ff;
      unique case (state_ff)
         bba_pkg::ST_CLEAR: begin
            if (addr_ff == LAST_ADDR) begin
               state_in = bba_pkg::ST_IDLE;
               addr_in  = '0;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         bba_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = bba_pkg::ST_READ;
               cmd_in   = req.command;
               id_in    = req.blk_num;
               if (req.command != bba_pkg::CMD_ALLOC && req_id_ok) begin
                  addr_in = ADDR_W'(req.blk_num >> POS_W);
               end else begin
                  addr_in = '0;
               end
            end
         end
         bba_pkg::ST_READ: begin
            state_in = bba_pkg::ST_EVAL;
         end
         bba_pkg::ST_EVAL: begin
            if (scan_more) begin
               state_in = bba_pkg::ST_READ;
               addr_in  = addr_ff + 1'b1;
            end else begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bba_pkg::ST_CLEAR;
            addr_in  = '0;
         end
      endcase
   end

   // outputs
   always_comb begin
      mem_rd_addr  = addr_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = addr_ff;
      mem_wr_data  = mem_rd_data;
      done         = '0;
      done.status  = 1'b1;
      unique case (state_ff)
         bba_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = '0;
         end
         bba_pkg::ST_EVAL: begin
            done.valid = !scan_more;
            unique case (cmd_ff)
               bba_pkg::CMD_ALLOC: begin
                  if (zero_ok) begin
                     mem_wr_en              = 1'b1;
                     mem_wr_data[zero_pos]  = 1'b1;
                     done.status            = 1'b0;
                     done.granted           = 8'(zero_idx);
                     done.inc               = 1'b1;
                  end
               end
               bba_pkg::CMD_REQUEST: begin
                  if (id_ff != 8'd0 && id_ok && !id_bit) begin
                     mem_wr_en           = 1'b1;
                     mem_wr_data[id_pos] = 1'b1;
                     done.status         = 1'b0;
                     done.granted        = id_ff;
                     done.inc            = 1'b1;
                  end
               end
               bba_pkg::CMD_RELEASE: begin
                  if (id_ok) begin
                     done.status = 1'b0;
                     if (id_bit) begin
                        mem_wr_en           = 1'b1;
                        mem_wr_data[id_pos] = 1'b0;
                        done.dec            = 1'b1;
                     end
                  end
               end
               default: begin
                  done.status = 1'b1;
               end
            endcase
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == bba_pkg::ST_READ)
      else $error("accepted word did not start a map read");

   a_done_in_eval: assert property (@(posedge clock) disable iff (reset)
      done.valid |-> state_ff == bba_pkg::ST_EVAL && !scan_more)
      else $error("result produced outside evaluation");

   a_no_double_mark: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bba_pkg::ST_EVAL && cmd_ff == bba_pkg::CMD_REQUEST && mem_wr_en)
      |-> !id_bit)
      else $error("request marked a block already in use");

   a_inc_dec_excl: assert property (@(posedge clock) disable iff (reset)
      !(done.inc && done.dec))
      else $error("count incremented and decremented together");
`endif

endmodule

`default_nettype wire

[sv/bitmap_block_allocator_unit.sv]
// bitmap block allocator top level: map memory, sequencer, used count, result register
// depends on bba_pkg, bba_map_mem, bba_ctrl
// request, release and command three: busy through a map read and its evaluation, result registered after evaluation
// allocate: scans k map words from word 0 (1 to ceil(NUM_BLOCKS/64)), a read and an evaluation per word
// one command at a time, next word taken as rsp_valid shows; receiver cannot stall
// reset: synchronous; a clearing pass that zeroes each of the ceil(NUM_BLOCKS/64) map words holds busy high
`default_nettype none

module bitmap_block_allocator_unit #(
   parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire bba_pkg::req_type req_data,
   output logic                  rsp_valid,
   output bba_pkg::rsp_type      rsp_data
);

   localparam int DEPTH  = (NUM_BLOCKS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(NUM_BLOCKS);
   localparam logic [CNT_W-1:0] USABLE = CNT_W'(NUM_BLOCKS - 1);

   logic [ADDR_W-1:0]          mem_rd_addr;
   logic [bba_pkg::WORD_W-1:0] mem_rd_data;
   logic                       mem_wr_en;
   logic [ADDR_W-1:0]          mem_wr_addr;
   logic [bba_pkg::WORD_W-1:0] mem_wr_data;
   bba_pkg::done_type          done;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bba_pkg::rsp_type  rsp_ff, rsp_in;

   bba_map_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   bba_ctrl #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .DEPTH      (DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req         (req_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .done        (done)
   );

   always_comb begin
      count_in = count_ff;
      if (done.inc) begin
         count_in = count_ff + 1'b1;
      end else if (done.dec) begin
         count_in = count_ff - 1'b1;
      end
      rsp_valid_in         = done.valid;
      rsp_in.status        = done.status;
      rsp_in.granted_block = done.granted;
      rsp_in.used_count    = 8'(count_in);
      rsp_in.free_count    = 8'(USABLE - count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= USABLE)
      else $error("used count beyond usable blocks");

   a_counts_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 8'(rsp_data.used_count + rsp_data.free_count) == 8'(NUM_BLOCKS - 1))
      else $error("used and free counts disagree");

   a_reject_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.granted_block == 8'd0)
      else $error("rejected word carries a block number");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for bitmap_block_allocator_unit: directed and random commands,
// predicted against an in-bench copy of the used-block map and count
// depends on bba_pkg and the allocator RTL
module testbench;

   localparam int NBLK       = bba_pkg::NUM_BLOCKS_DEF;
   localparam int STALL_MAX  = 2000;
   localparam int TAIL_WAIT  = 20;
   localparam int ITEM_GOAL  = 950;
   localparam int FILL_AT    = 300;
   localparam int IDLE_PCT   = 26;

   typedef struct packed {
      bba_pkg::req_type word;
      logic             drain;
      logic             gap_ok;
   } slot_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   bba_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_valid;
   bba_pkg::rsp_type rsp_data;

   slot_type         cmd_backlog[$];
   bba_pkg::rsp_type allocator_outcomes[$];
   logic [NBLK-1:0]  shadow_map = '0;
   int               shadow_used = 0;
   int               stim_total = 0;
   int               fail_count = 0;
   int               quiet_cycles = 0;

   bitmap_block_allocator_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic bba_pkg::rsp_type allocate_step(input bba_pkg::req_type w);
      bba_pkg::rsp_type r;
      int               lowest;
      int               id;
      r = '0;
      r.status = 1'b1;
      id = w.blk_num;
      case (bba_pkg::cmd_type'(w.command))
         bba_pkg::CMD_ALLOC: begin
            lowest = NBLK;
            for (int i = NBLK - 1; i >= 0; i--) begin
               if (!shadow_map[i]) begin
                  lowest = i;
               end
            end
            if (lowest < NBLK - 1) begin
               shadow_map[lowest] = 1'b1;
               shadow_used++;
               r.status = 1'b0;
               r.granted_block = lowest[7:0];
            end
         end
         bba_pkg::CMD_REQUEST: begin
            if (id != 0 && id < NBLK - 1 && !shadow_map[id]) begin
               shadow_map[id] = 1'b1;
               shadow_used++;
               r.status = 1'b0;
               r.granted_block = id[7:0];
            end
         end
         bba_pkg::CMD_RELEASE: begin
            if (id < NBLK - 1) begin
               if (shadow_map[id]) begin
                  shadow_map[id] = 1'b0;
                  shadow_used--;
               end
               r.status = 1'b0;
            end
         end
         default: begin
         end
      endcase
      r.used_count = shadow_used[7:0];
      r.free_count = 8'(NBLK - 1 - shadow_used);
      return r;
   endfunction

   function automatic int pick_id();
      int roll;
      roll = $urandom_range(99);
      if (roll < 4) begin
         return 0;
      end else if (roll < 8) begin
         return NBLK - 2;
      end else if (roll < 11) begin
         return NBLK - 1;
      end
      return $urandom_range(255);
   endfunction

   task automatic queue_cmd(input bba_pkg::cmd_type c, input int id, input bit drain);
      slot_type s;
      s.word.command = c;
      s.word.blk_num = id[7:0];
      s.drain = drain;
      s.gap_ok = !(stim_total >= 420 && stim_total < 600);
      cmd_backlog.push_back(s);
      stim_total++;
   endtask

   task automatic queue_burst();
      int mode;
      int len;
      int roll;
      mode = $urandom_range(2);
      len = (mode == 2) ? 20 : 40;
      for (int n = 0; n < len; n++) begin
         roll = $urandom_range(99);
         case (mode)
            0: begin
               if (roll < 75) begin
                  queue_cmd(bba_pkg::CMD_ALLOC, $urandom_range(255), 1'b0);
               end else if (roll < 90) begin
                  queue_cmd(bba_pkg::CMD_REQUEST, pick_id(), 1'b0);
               end else begin
                  queue_cmd(bba_pkg::CMD_RELEASE, pick_id(), 1'b0);
               end
            end
            1: begin
               if (roll < 70) begin
                  queue_cmd(bba_pkg::CMD_RELEASE, pick_id(), 1'b0);
               end else if (roll < 90) begin
                  queue_cmd(bba_pkg::CMD_ALLOC, $urandom_range(255), 1'b0);
               end else begin
                  queue_cmd(bba_pkg::CMD_REQUEST, pick_id(), 1'b0);
               end
            end
            default: begin
               queue_cmd(bba_pkg::cmd_type'($urandom_range(3)), $urandom_range(255), 1'b0);
            end
         endcase
      end
   endtask

   // driver
   always @(posedge clock) begin : driver
      logic     accepted;
      logic     next_start;
      slot_type head;
      if (reset) begin
         start <= 1'b0;
      end else begin
         accepted = start && !busy;
         if (accepted) begin
            allocator_outcomes.push_back(allocate_step(req_data));
         end
         if (!start || accepted) begin
            next_start = 1'b0;
            if (cmd_backlog.size() > 0) begin
               head = cmd_backlog[0];
               if (head.drain && allocator_outcomes.size() > 0) begin
                  next_start = 1'b0;
               end else if (head.gap_ok && $urandom_range(99) < IDLE_PCT) begin
                  next_start = 1'b0;
               end else begin
                  req_data <= head.word;
                  next_start = 1'b1;
                  void'(cmd_backlog.pop_front());
               end
            end
            start <= next_start;
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // monitor
   always @(posedge clock) begin : monitor
      bba_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (allocator_outcomes.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = allocator_outcomes.pop_front();
            check_field("status", want.status, rsp_data.status);
            check_field("granted_block", want.granted_block, rsp_data.granted_block);
            check_field("used_count", want.used_count, rsp_data.used_count);
            check_field("free_count", want.free_count, rsp_data.free_count);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      queue_cmd(bba_pkg::CMD_REQUEST, 0, 1'b0);
      queue_cmd(bba_pkg::CMD_RELEASE, 0, 1'b0);
      queue_cmd(bba_pkg::CMD_ALLOC, 8'h00, 1'b0);
      queue_cmd(bba_pkg::CMD_ALLOC, 8'hff, 1'b0);
      queue_cmd(bba_pkg::CMD_REQUEST, 1, 1'b0);
      queue_cmd(bba_pkg::CMD_REQUEST, NBLK - 2, 1'b0);
      queue_cmd(bba_pkg::CMD_REQUEST, NBLK - 1, 1'b0);
      queue_cmd(bba_pkg::CMD_RELEASE, NBLK - 1, 1'b0);
      queue_cmd(bba_pkg::CMD_RELEASE, NBLK - 2, 1'b0);
      queue_cmd(bba_pkg::CMD_RELEASE, NBLK - 2, 1'b0);
      queue_cmd(bba_pkg::CMD_NONE, 8'hff, 1'b0);
      queue_cmd(bba_pkg::CMD_NONE, 8'h00, 1'b0);
      queue_cmd(bba_pkg::CMD_REQUEST, 128, 1'b0);
      queue_cmd(bba_pkg::CMD_REQUEST, 8'haa, 1'b0);
      queue_cmd(bba_pkg::CMD_RELEASE, 8'h55, 1'b0);
      queue_cmd(bba_pkg::CMD_RELEASE, 0, 1'b0);
      queue_cmd(bba_pkg::CMD_ALLOC, 8'h55, 1'b0);
      queue_cmd(bba_pkg::CMD_ALLOC, 8'haa, 1'b0);
      queue_cmd(bba_pkg::CMD_RELEASE, 1, 1'b0);
      queue_cmd(bba_pkg::CMD_ALLOC, 8'h0f, 1'b0);
      queue_cmd(bba_pkg::CMD_REQUEST, 127, 1'b0);

      while (stim_total < FILL_AT) begin
         queue_burst();
      end
      // fill the map until allocation runs into the reserved block
      queue_cmd(bba_pkg::CMD_ALLOC, $urandom_range(255), 1'b1);
      for (int n = 0; n < NBLK + 8; n++) begin
         queue_cmd(bba_pkg::CMD_ALLOC, $urandom_range(255), 1'b0);
      end
      queue_cmd(bba_pkg::CMD_REQUEST, NBLK - 2, 1'b0);
      queue_cmd(bba_pkg::CMD_REQUEST, $urandom_range(1, NBLK - 2), 1'b0);
      while (stim_total < ITEM_GOAL) begin
         queue_burst();
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (cmd_backlog.size() > 0 || start || allocator_outcomes.size() > 0) begin
         @(negedge clock);
      end
      repeat (TAIL_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
